// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/b64enc_pkg.sv =====
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the alphabet lookup of the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

  // Character constants of the standard alphabet.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] PAD_CHAR     = 8'h3D;

  // Number of six-bit slots one input byte can produce.
  localparam int unsigned SLOTS = 4;

  // Position within the current three-byte group.
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } b64_phase_t;

  // One input request.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64_in_t;

  // One result request.
  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       message_end;
  } b64_out_t;

  // Work handed from the front end to the back end for one input byte.
  typedef struct packed {
    logic [SLOTS-1:0][5:0] code;     // six-bit symbols, slot 0 first
    logic [SLOTS-1:0]      pad;      // slot is '=' padding
    logic [1:0]            last_idx; // index of the final slot
    logic                  fin;      // byte closed the message
  } b64_job_t;

  // Map a six-bit symbol to its ASCII character.
  function automatic logic [7:0] sym2char(input logic [5:0] six);
    logic [7:0] s;
    s = {2'b00, six};
    if (six < 6'd26) begin
      return 8'(CHAR_UPPER_A + s);
    end else if (six < 6'd52) begin
      return 8'(CHAR_LOWER_A + s - 8'd26);
    end else if (six < 6'd62) begin
      return 8'(CHAR_DIGIT_0 + s - 8'd52);
    end else if (six == 6'd62) begin
      return CHAR_PLUS;
    end else begin
      return CHAR_SLASH;
    end
  endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
// ----------------------------------------------------------------------------
// b64enc_front
// Takes input bytes, tracks the group position and leftover bits, and turns
// each byte into a job of one to four symbol slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  b64enc_pkg::b64_in_t  in_data,
  output b64enc_pkg::b64_job_t job
);

  b64enc_pkg::b64_phase_t phase_r, phase_nxt;
  logic [3:0]             carry_r, carry_nxt;
  logic [7:0]             b;

  assign b = in_data.data_byte;

  // Next group position and leftover bits.
  always_comb begin
    phase_nxt = phase_r;
    carry_nxt = carry_r;
    if (accept) begin
      unique case (phase_r)
        b64enc_pkg::PH_1: begin
          phase_nxt = b64enc_pkg::PH_2;
          carry_nxt = b[3:0];
        end
        b64enc_pkg::PH_2: begin
          phase_nxt = b64enc_pkg::PH_0;
          carry_nxt = 4'd0;
        end
        default: begin
          phase_nxt = b64enc_pkg::PH_1;
          carry_nxt = {2'b00, b[1:0]};
        end
      endcase
      // A final byte always returns the encoder to its starting state.
      if (in_data.final_byte) begin
        phase_nxt = b64enc_pkg::PH_0;
        carry_nxt = 4'd0;
      end
    end
  end

  // Symbol slots produced by the current byte.
  always_comb begin
    job          = '0;
    job.fin      = in_data.final_byte;
    unique case (phase_r)
      b64enc_pkg::PH_1: begin
        job.code[0] = {carry_r[1:0], b[7:4]};
        if (in_data.final_byte) begin
          job.code[1]  = {b[3:0], 2'b00};
          job.pad[2]   = 1'b1;
          job.last_idx = 2'd2;
        end
      end
      b64enc_pkg::PH_2: begin
        job.code[0]  = {carry_r[3:0], b[7:6]};
        job.code[1]  = b[5:0];
        job.last_idx = 2'd1;
      end
      default: begin
        job.code[0] = b[7:2];
        if (in_data.final_byte) begin
          job.code[1]  = {b[1:0], 4'b0000};
          job.pad[2]   = 1'b1;
          job.pad[3]   = 1'b1;
          job.last_idx = 2'd3;
        end
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64enc_pkg::PH_0;
      carry_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
    end
  end

  `ASSERT_CLK(a_final_restarts, clk, rst_n, (accept && in_data.final_byte) |=> (phase_r == b64enc_pkg::PH_0 && carry_r == 4'd0), "final byte did not restart the group")
  `ASSERT_CLK(a_phase2_from_phase1, clk, rst_n, (phase_r == b64enc_pkg::PH_2 && $past(phase_r) != b64enc_pkg::PH_2) |-> $past(phase_r) == b64enc_pkg::PH_1, "group position skipped a byte")
  `ASSERT_CLK(a_carry_narrow_ph1, clk, rst_n, (phase_r == b64enc_pkg::PH_1) |-> carry_r[3:2] == 2'b00, "stray leftover bits after first byte")

endmodule

// ===== rtl/b64enc_fifo.sv =====
// ----------------------------------------------------------------------------
// b64enc_fifo
// Short job queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_fifo #(
  parameter int unsigned DEPTH = 2  // at least 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  b64enc_pkg::b64_job_t wr_job,
  output logic                 full,
  input  logic                 pop,
  output b64enc_pkg::b64_job_t rd_job,
  output logic                 empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64enc_pkg::b64_job_t mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage, no reset needed.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst_n, count_r <= CNT_W'(DEPTH), "queue occupancy beyond depth")
  `ASSERT_CLK(a_pop_drains, clk, rst_n, (do_pop && !do_push) |=> count_r == $past(count_r) - 1'b1, "pop did not lower occupancy")

endmodule

// ===== rtl/b64enc_back.sv =====
// ----------------------------------------------------------------------------
// b64enc_back
// Walks the slots of the job at the queue head into the output register,
// one character per cycle while that register is free or being popped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64enc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  b64enc_pkg::b64_job_t job,
  input  logic                 job_empty,
  output logic                 job_pop,
  output b64enc_pkg::b64_out_t out_data,
  output logic                 out_empty,
  input  logic                 out_pop
);

  logic [1:0]           idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  b64enc_pkg::b64_out_t out_data_r, out_data_nxt;
  logic                 advance;
  logic                 slot_last;

  // A slot moves when there is work and the output register is free or draining.
  assign advance   = !job_empty && (!out_valid_r || out_pop);
  assign slot_last = (idx_r == job.last_idx);
  assign job_pop   = advance && slot_last;
  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

  // Slot counter and output register next values.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      idx_nxt       = slot_last ? 2'd0 : idx_r + 2'd1;
      out_valid_nxt = 1'b1;
      out_data_nxt.out_char    = job.pad[idx_r] ? b64enc_pkg::PAD_CHAR
                                                : b64enc_pkg::sym2char(job.code[idx_r]);
      out_data_nxt.run_last    = slot_last;
      out_data_nxt.message_end = slot_last && job.fin;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  `ASSERT_CLK(a_idx_in_job, clk, rst_n, !job_empty |-> idx_r <= job.last_idx, "slot index past end of job")
  `ASSERT_CLK(a_end_is_last, clk, rst_n, (out_valid_r && out_data_r.message_end) |-> out_data_r.run_last, "message end on a non-final character")
  `ASSERT_CLK(a_idle_idx, clk, rst_n, job_empty |-> idx_r == 2'd0, "slot index left over with no job")

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Streaming base64 encoder (standard alphabet, '=' padding). Each input
// request carries one message byte and a flag for the last byte; each byte
// yields one to four characters on the result side: one in the first two
// positions of a group, two in the third, and up to four on a final byte
// (padding included). The back end emits one character per cycle from the
// job at the head of the queue while the output register is free or being
// popped. A byte's job passes through the job queue and then the output
// register before its first character appears. run_last marks the last
// character of each byte and message_end the last character of the
// message; an empty message gives nothing.
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Top level: front end, job queue and character back end.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  b64enc_pkg::b64_in_t  in_data,
  output logic                 in_full,
  output logic                 out_empty,
  output b64enc_pkg::b64_out_t out_data,
  input  logic                 out_pop
);

  b64enc_pkg::b64_job_t front_job;
  b64enc_pkg::b64_job_t head_job;
  logic                 accept;
  logic                 q_full, q_empty, q_pop;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  b64enc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .job     (front_job)
  );

  b64enc_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (accept),
    .wr_job (front_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (head_job),
    .empty  (q_empty)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .job_empty (q_empty),
    .job_pop   (q_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
